[rtl/opamp_newton_damped_output_top_macros.svh]
// Assertion helpers used by the RTL core.
`ifndef OPAMP_NEWTON_DAMPED_OUTPUT_TOP_MACROS_SVH
`define OPAMP_NEWTON_DAMPED_OUTPUT_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ONDA_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("onda: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ONDA_ASSERT_NXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("onda: next-cycle check failed");

`endif

[rtl/onda_pkg.sv]
`default_nettype none

package onda_pkg;

    localparam int VOLT_W  = 48;   // Q15.32 voltages
    localparam int REG32_W = 32;
    localparam int CFG_W   = 48;   // widest config register
    localparam int IDX_W   = 3;
    localparam int ADD_W   = 97;   // shared adder: signed blend numerator
    localparam int CNT_W   = 7;

    localparam logic [12:0] MICROVOLT = 13'd4295;
    localparam logic [62:0] MAG_CAP   = 63'h4000_0000_0000_0000;

    localparam logic [REG32_W-1:0] GAIN_RST     = 32'd65536000;
    localparam logic [REG32_W-1:0] DAMPING_RST  = 32'd4;
    localparam logic [REG32_W-1:0] ACCURACY_RST = 32'd4295;
    localparam logic [VOLT_W-1:0]  RAIL_HI_RST  = 48'h0005_0000_0000;
    localparam logic [VOLT_W-1:0]  RAIL_LO_RST  = 48'hFFFB_0000_0000;

    typedef enum logic [IDX_W-1:0] {
        CFG_GAIN      = 3'd0,
        CFG_DAMPING_K = 3'd1,
        CFG_ACCURACY  = 3'd2,
        CFG_RAIL_HIGH = 3'd3,
        CFG_RAIL_LOW  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic        [REG32_W-1:0] gain;
        logic        [REG32_W-1:0] damping_k;
        logic        [REG32_W-1:0] accuracy;
        logic signed [VOLT_W-1:0]  rail_high;
        logic signed [VOLT_W-1:0]  rail_low;
    } cfg_t;

    typedef struct packed {
        logic [ADD_W-1:0] a;
        logic [ADD_W-1:0] b;
        logic             sub;
    } add_req_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] drive;
        logic                     conv;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VABS,
        ST_GMUL,
        ST_GNEG,
        ST_RAIL1,
        ST_CONV,
        ST_NUDGE,
        ST_DSUB,
        ST_DABS,
        ST_DVS,
        ST_PABS,
        ST_AMUL,
        ST_ASIGN,
        ST_BMUL,
        ST_NABS,
        ST_DIV,
        ST_QUOT,
        ST_FINAL,
        ST_EMIT
    } state_t;

    function automatic logic [ADD_W-1:0] sx48(input logic [VOLT_W-1:0] v);
        return {{(ADD_W-VOLT_W){v[VOLT_W-1]}}, v};
    endfunction

    function automatic logic [ADD_W-1:0] sx64(input logic [63:0] v);
        return {{(ADD_W-64){v[63]}}, v};
    endfunction

endpackage

`default_nettype wire

[rtl/onda_addsub.sv]
`default_nettype none

// Shared add/subtract unit: sum = a + b or a - b.
module onda_addsub (
    input  onda_pkg::add_req_t           req,
    output logic [onda_pkg::ADD_W-1:0]   sum
);
    import onda_pkg::*;

    logic [ADD_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = req.a + b_op + {{(ADD_W-1){1'b0}}, req.sub};

endmodule

`default_nettype wire

[rtl/onda_core.sv]
`default_nettype none
`include "opamp_newton_damped_output_top_macros.svh"

// Sequencer and datapath around the shared adder.
module onda_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  onda_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [onda_pkg::VOLT_W-1:0]     in_plus,
    input  logic [onda_pkg::VOLT_W-1:0]     in_minus,
    output logic                            res_valid,
    input  logic                            res_ready,
    output onda_pkg::res_t                  res
);
    import onda_pkg::*;

    state_t state_reg, state_next;

    logic                     flag_reg, flag_next;
    logic                     pflag_reg, pflag_next;
    logic signed [VOLT_W-1:0] prev_out_reg, prev_out_next;
    logic signed [VOLT_W-1:0] prev_diff_reg, prev_diff_next;

    logic signed [VOLT_W-1:0] vd_reg, vd_next;
    logic [VOLT_W-1:0]        vmag_reg, vmag_next;
    logic [ADD_W-1:0]         acc_reg, acc_next;
    logic [ADD_W-1:0]         mcand_reg, mcand_next;
    logic [48:0]              mplier_reg, mplier_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [63:0]       o_reg, o_next;
    logic [48:0]              din_reg, din_next;
    logic [49:0]              dvs_reg, dvs_next;
    logic [48:0]              rem_reg, rem_next;
    logic                     neg_reg, neg_next;

    add_req_t         add_req;
    logic [ADD_W-1:0] add_sum;

    onda_addsub u_addsub (
        .req (add_req),
        .sum (add_sum)
    );

    // decode helpers
    logic signed [63:0] rh64, rl64;
    logic [62:0]        gmag;
    logic [62:0]        qmag;
    logic signed [50:0] d51, band;
    logic               in_band;
    logic [49:0]        shifted;
    logic               take;

    assign rh64 = {{(64-VOLT_W){cfg.rail_high[VOLT_W-1]}}, cfg.rail_high};
    assign rl64 = {{(64-VOLT_W){cfg.rail_low[VOLT_W-1]}}, cfg.rail_low};

    // gain product >> 16, capped at 2^62
    assign gmag = (|acc_reg[96:78]) ? MAG_CAP : {1'b0, acc_reg[77:16]};
    // quotient capped at 2^62
    assign qmag = ((|acc_reg[95:63]) || (acc_reg[62] && (|acc_reg[61:0])))
                  ? MAG_CAP : acc_reg[62:0];

    assign d51     = {{1{add_sum[49]}}, add_sum[49:0]};
    assign band    = {19'd0, cfg.accuracy};
    assign in_band = (d51 < band) && (d51 > -band);

    assign shifted = {rem_reg, acc_reg[95]};
    assign take    = ~add_sum[ADD_W-1];

    assign res.drive = o_reg[VOLT_W-1:0];
    assign res.conv  = pflag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            flag_reg      <= 1'b1;
            prev_out_reg  <= '0;
            prev_diff_reg <= '0;
        end else begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            prev_out_reg  <= prev_out_next;
            prev_diff_reg <= prev_diff_next;
        end
    end

    always_ff @(posedge aclk) begin
        pflag_reg  <= pflag_next;
        vd_reg     <= vd_next;
        vmag_reg   <= vmag_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
        o_reg      <= o_next;
        din_reg    <= din_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
    end

    always_comb begin
        state_next     = state_reg;
        flag_next      = flag_reg;
        pflag_next     = pflag_reg;
        prev_out_next  = prev_out_reg;
        prev_diff_next = prev_diff_reg;
        vd_next        = vd_reg;
        vmag_next      = vmag_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        o_next         = o_reg;
        din_next       = din_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        add_req.a      = '0;
        add_req.b      = '0;
        add_req.sub    = 1'b0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                add_req.a   = sx48(in_plus);
                add_req.b   = sx48(in_minus);
                add_req.sub = 1'b1;
                if (in_valid) begin
                    // saturate the 49-bit difference to 48 bits
                    if (add_sum[48] && !add_sum[47]) begin
                        vd_next = {1'b1, {(VOLT_W-1){1'b0}}};
                    end else if (!add_sum[48] && add_sum[47]) begin
                        vd_next = {1'b0, {(VOLT_W-1){1'b1}}};
                    end else begin
                        vd_next = add_sum[VOLT_W-1:0];
                    end
                    state_next = ST_VABS;
                end
            end
            ST_VABS: begin
                add_req.b   = sx48(vd_reg);
                add_req.sub = vd_reg[VOLT_W-1];
                vmag_next   = add_sum[VOLT_W-1:0];
                mcand_next  = {{(ADD_W-VOLT_W){1'b0}}, add_sum[VOLT_W-1:0]};
                mplier_next = {17'd0, cfg.gain};
                acc_next    = '0;
                cnt_next    = CNT_W'(REG32_W);
                state_next  = ST_GMUL;
            end
            ST_GMUL, ST_AMUL, ST_BMUL: begin
                // one shift-add step per cycle
                add_req.a   = acc_reg;
                add_req.b   = mplier_reg[0] ? mcand_reg : '0;
                add_req.sub = (state_reg == ST_BMUL) && vd_reg[VOLT_W-1];
                acc_next    = add_sum;
                mcand_next  = {mcand_reg[ADD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[48:1]};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    case (state_reg)
                        ST_GMUL: state_next = ST_GNEG;
                        ST_AMUL: state_next = ST_ASIGN;
                        default: state_next = ST_NABS;
                    endcase
                end
            end
            ST_GNEG: begin
                add_req.b   = {{(ADD_W-63){1'b0}}, gmag};
                add_req.sub = vd_reg[VOLT_W-1];
                o_next      = add_sum[63:0];
                state_next  = ST_RAIL1;
            end
            ST_RAIL1: begin
                if (o_reg > rh64) begin
                    o_next = rh64;
                end else if (o_reg < rl64) begin
                    o_next = rl64;
                end
                state_next = ST_CONV;
            end
            ST_CONV: begin
                add_req.a   = sx64(o_reg);
                add_req.b   = sx48(prev_out_reg);
                add_req.sub = 1'b1;
                if (in_band) begin
                    flag_next  = 1'b1;
                    state_next = ST_IDLE;
                end else if (flag_reg) begin
                    pflag_next = 1'b0;
                    state_next = ST_NUDGE;
                end else begin
                    pflag_next = 1'b1;
                    if (prev_diff_reg == vd_reg) begin
                        state_next = ST_FINAL;
                    end else begin
                        state_next = ST_DSUB;
                    end
                end
            end
            ST_NUDGE: begin
                add_req.a   = sx48(prev_out_reg);
                add_req.b   = {{(ADD_W-13){1'b0}}, MICROVOLT};
                add_req.sub = vd_reg[VOLT_W-1] || (vd_reg == '0);
                o_next      = add_sum[63:0];
                state_next  = ST_FINAL;
            end
            ST_DSUB: begin
                add_req.a   = sx48(prev_diff_reg);
                add_req.b   = sx48(vd_reg);
                add_req.sub = 1'b1;
                acc_next    = add_sum;
                state_next  = ST_DABS;
            end
            ST_DABS: begin
                add_req.b   = acc_reg;
                add_req.sub = acc_reg[ADD_W-1];
                din_next    = add_sum[48:0];
                state_next  = ST_DVS;
            end
            ST_DVS: begin
                add_req.a  = {{(ADD_W-49){1'b0}}, din_reg};
                add_req.b  = {{(ADD_W-REG32_W){1'b0}}, cfg.damping_k};
                dvs_next   = add_sum[49:0];
                state_next = ST_PABS;
            end
            ST_PABS: begin
                add_req.b   = sx48(prev_out_reg);
                add_req.sub = prev_out_reg[VOLT_W-1];
                mcand_next  = {{(ADD_W-VOLT_W){1'b0}}, add_sum[VOLT_W-1:0]};
                mplier_next = din_reg;
                acc_next    = '0;
                cnt_next    = CNT_W'(49);
                state_next  = ST_AMUL;
            end
            ST_ASIGN: begin
                add_req.b   = acc_reg;
                add_req.sub = prev_out_reg[VOLT_W-1];
                acc_next    = add_sum;
                mcand_next  = {{(ADD_W-VOLT_W){1'b0}}, vmag_reg};
                mplier_next = {36'd0, MICROVOLT};
                cnt_next    = CNT_W'(13);
                state_next  = ST_BMUL;
            end
            ST_NABS: begin
                add_req.b   = acc_reg;
                add_req.sub = acc_reg[ADD_W-1];
                neg_next    = acc_reg[ADD_W-1];
                acc_next    = add_sum;
                rem_next    = '0;
                cnt_next    = CNT_W'(ADD_W-1);
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                // restoring step: numerator shifts out the top, quotient in the bottom
                add_req.a   = {{(ADD_W-50){1'b0}}, shifted};
                add_req.b   = {{(ADD_W-50){1'b0}}, dvs_reg};
                add_req.sub = 1'b1;
                rem_next    = take ? add_sum[48:0] : shifted[48:0];
                acc_next    = {1'b0, acc_reg[ADD_W-3:0], take};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT: begin
                add_req.b   = {{(ADD_W-63){1'b0}}, qmag};
                add_req.sub = neg_reg;
                o_next      = add_sum[63:0];
                state_next  = ST_FINAL;
            end
            ST_FINAL: begin
                if (o_reg >= rh64) begin
                    o_next = rh64;
                end else if (o_reg <= rl64) begin
                    o_next = rl64;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    prev_out_next  = o_reg[VOLT_W-1:0];
                    prev_diff_next = vd_reg;
                    flag_next      = pflag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ONDA_ASSERT_NXT(a_accept_starts, aclk, aresetn, in_valid && in_ready, state_reg == ST_VABS)
    `ONDA_ASSERT_IMP(a_div_rem_lt, aclk, aresetn, state_reg == ST_DIV, {1'b0, rem_reg} < dvs_reg)
    `ONDA_ASSERT_IMP(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, dvs_reg != '0)
    `ONDA_ASSERT_IMP(a_emit_fits, aclk, aresetn, state_reg == ST_EMIT,
                     (o_reg[63:47] == '0) || (o_reg[63:47] == '1))

endmodule

`default_nettype wire

[rtl/opamp_newton_damped_output_top.sv]
`default_nettype none

// Damped op-amp output stage for a Newton solver step. Each request carries the
// two pin voltages (signed Q15.32); the block forms the saturated differential,
// scales it by the Q16.16 gain, clamps it to the rails and checks it against
// the accuracy band around the last output. Inside the band the block only sets
// its converged flag and returns nothing. Otherwise it returns one request with
// the new clamped drive voltage and the flag after this step. All arithmetic
// runs one step per cycle through a single 97-bit adder: 32 shift-add steps
// for the gain product, 49 + 13 for the blend numerator and 96 for the
// restoring divide. s_ready is high only while the sequencer is idle; the
// output register lets the next request be accepted while a result still
// waits on m_ready. Config writes (gain, damping_k, accuracy, rail_high,
// rail_low at indexes 0..4) take effect at once and belong only in idle time;
// other indexes are ignored.
module opamp_newton_damped_output_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input requests
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [onda_pkg::VOLT_W-1:0]     s_plus_voltage,
    input  logic [onda_pkg::VOLT_W-1:0]     s_minus_voltage,
    // result requests
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [onda_pkg::VOLT_W-1:0]     m_drive_voltage,
    output logic                            m_converged_now,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [onda_pkg::IDX_W-1:0]      cfg_index,
    input  logic [onda_pkg::CFG_W-1:0]      cfg_wr_data
);
    import onda_pkg::*;

    cfg_t cfg_reg;

    // config register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain      <= GAIN_RST;
            cfg_reg.damping_k <= DAMPING_RST;
            cfg_reg.accuracy  <= ACCURACY_RST;
            cfg_reg.rail_high <= RAIL_HI_RST;
            cfg_reg.rail_low  <= RAIL_LO_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN:      cfg_reg.gain      <= cfg_wr_data[REG32_W-1:0];
                CFG_DAMPING_K: cfg_reg.damping_k <= cfg_wr_data[REG32_W-1:0];
                CFG_ACCURACY:  cfg_reg.accuracy  <= cfg_wr_data[REG32_W-1:0];
                CFG_RAIL_HIGH: cfg_reg.rail_high <= cfg_wr_data[VOLT_W-1:0];
                CFG_RAIL_LOW:  cfg_reg.rail_low  <= cfg_wr_data[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    logic res_valid;
    logic res_ready;
    res_t res;

    onda_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_plus   (s_plus_voltage),
        .in_minus  (s_minus_voltage),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: one result slot, refilled in the cycle it drains
    logic                 m_valid_reg, m_valid_next;
    logic [VOLT_W-1:0]    m_drive_reg;
    logic                 m_conv_reg;

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_drive_reg <= res.drive;
            m_conv_reg  <= res.conv;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive_voltage = m_drive_reg;
    assign m_converged_now = m_conv_reg;

endmodule

`default_nettype wire
